// ----- sv/bmrp_pkg.sv -----
// ---------------------------------------------------------------------------
// bmrp_pkg
// types and constants shared by the monitor record parser modules
// ---------------------------------------------------------------------------
package bmrp_pkg;

    localparam int TimeW  = 35;
    localparam int TickW  = 32;
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [7:0] MarkA = 8'h41;
    localparam logic [7:0] MarkB = 8'h42;
    localparam logic [7:0] MarkC = 8'h43;
    localparam logic [7:0] MarkD = 8'h44;

    localparam logic [2:0] KindHeader = 3'd0;
    localparam logic [2:0] KindCmdData = 3'd1;
    localparam logic [2:0] KindStatus = 3'd2;
    localparam logic [2:0] KindRespData = 3'd3;
    localparam logic [2:0] KindSwitch = 3'd4;
    localparam logic [2:0] KindDropped = 3'd5;
    localparam logic [2:0] KindMalformed = 3'd6;

    localparam logic [3:0] HdrTick0 = 4'd1;
    localparam logic [3:0] HdrTick3 = 4'd4;
    localparam logic [3:0] HdrChan = 4'd6;
    localparam logic [3:0] HdrErr = 4'd7;
    localparam logic [3:0] HdrCmdLen = 4'd8;
    localparam logic [3:0] HdrRespLen = 4'd9;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HDR,
        PH_CMDW,
        PH_CMDD,
        PH_STATW,
        PH_RESPD,
        PH_SWITCH
    } t_phase;

    typedef struct packed {
        logic [2:0]       kind;
        logic [1:0]       marker;
        logic [TickW-1:0] tick;
        logic             chan;
        logic [7:0]       err;
        logic [15:0]      word;
    } t_event;

    typedef struct packed {
        logic [15:0]      word_value;
        logic [5:0]       word_count;
        logic [4:0]       subaddress;
        logic             transmit;
        logic [4:0]       rt_address;
        logic [7:0]       error_code;
        logic             bus_channel;
        logic [TimeW-1:0] interval_us;
        logic [TimeW-1:0] time_us;
        logic [1:0]       source_marker;
    } t_result;

endpackage

// ----- sv/bmrp_front.sv -----
// ---------------------------------------------------------------------------
// bmrp_front
// byte parser: cuts the log into records and classifies each word
// ---------------------------------------------------------------------------
module bmrp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_push,
    output bmrp_pkg::t_event o_event
);
    import bmrp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_idx, n_idx;
    logic [TickW-1:0] r_tick, n_tick;
    logic [1:0]       r_marker, n_marker;
    logic             r_chan, n_chan;
    logic [7:0]       r_err, n_err;
    logic [7:0]       r_cmd_len, n_cmd_len;
    logic [7:0]       r_resp_len, n_resp_len;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_hold, n_hold;
    logic [7:0]       w_mark_off;
    logic [15:0]      w_word;
    t_event           w_ev;

    assign w_mark_off = i_byte - MarkA;
    assign w_word     = {i_byte, r_hold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_idx      <= '0;
            r_tick     <= '0;
            r_marker   <= '0;
            r_chan     <= 1'b0;
            r_err      <= '0;
            r_cmd_len  <= '0;
            r_resp_len <= '0;
            r_left     <= '0;
            r_hold     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_tick     <= n_tick;
            r_marker   <= n_marker;
            r_chan     <= n_chan;
            r_err      <= n_err;
            r_cmd_len  <= n_cmd_len;
            r_resp_len <= n_resp_len;
            r_left     <= n_left;
            r_hold     <= n_hold;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_tick     = r_tick;
        n_marker   = r_marker;
        n_chan     = r_chan;
        n_err      = r_err;
        n_cmd_len  = r_cmd_len;
        n_resp_len = r_resp_len;
        n_left     = r_left;
        n_hold     = r_hold;
        o_push     = 1'b0;
        w_ev       = '{kind: KindHeader, marker: r_marker, tick: r_tick, chan: r_chan,
                       err: r_err, word: w_word};
        if (i_valid) begin
            case (r_phase)
                PH_WAIT: begin
                    if (i_byte == MarkA || i_byte == MarkB) begin
                        n_marker = w_mark_off[1:0];
                        n_phase  = PH_HDR;
                        n_idx    = HdrTick0;
                        n_tick   = '0;
                    end else if (i_byte == MarkC || i_byte == MarkD) begin
                        n_marker = w_mark_off[1:0];
                        n_phase  = PH_SWITCH;
                    end else begin
                        o_push = 1'b1;
                        w_ev   = '{kind: KindDropped, marker: 2'd0, tick: '0, chan: 1'b0,
                                   err: i_byte, word: 16'd0};
                    end
                end
                PH_SWITCH: begin
                    n_phase = PH_WAIT;
                    o_push  = 1'b1;
                    w_ev    = '{kind: KindSwitch, marker: r_marker, tick: '0,
                                chan: (i_byte == 8'd0), err: 8'd0, word: 16'd0};
                end
                PH_HDR: begin
                    n_idx = r_idx + 4'd1;
                    if (r_idx >= HdrTick0 && r_idx <= HdrTick3) begin
                        case (r_idx[1:0])
                            2'd1:    n_tick[7:0]   = i_byte;
                            2'd2:    n_tick[15:8]  = i_byte;
                            2'd3:    n_tick[23:16] = i_byte;
                            default: n_tick[31:24] = i_byte;
                        endcase
                    end else if (r_idx == HdrChan) begin
                        n_chan = (i_byte != 8'd0);
                    end else if (r_idx == HdrErr) begin
                        n_err = i_byte;
                    end else if (r_idx == HdrCmdLen) begin
                        n_cmd_len = i_byte;
                    end else if (r_idx >= HdrRespLen) begin
                        n_idx      = '0;
                        n_resp_len = i_byte;
                        if (r_cmd_len[0] || r_cmd_len < 8'd2 ||
                            i_byte[0] || i_byte < 8'd2) begin
                            n_phase = PH_WAIT;
                            o_push  = 1'b1;
                            w_ev    = '{kind: KindMalformed, marker: r_marker, tick: r_tick,
                                        chan: r_chan, err: r_err, word: 16'd0};
                        end else begin
                            n_phase = PH_CMDW;
                        end
                    end
                end
                default: begin
                    if (r_idx == 4'd0) begin
                        n_hold = i_byte;
                        n_idx  = 4'd1;
                    end else begin
                        n_idx  = 4'd0;
                        o_push = 1'b1;
                        case (r_phase)
                            PH_CMDW: begin
                                w_ev.kind = KindHeader;
                                if (r_cmd_len > 8'd2) begin
                                    n_phase = PH_CMDD;
                                    n_left  = r_cmd_len - 8'd2;
                                end else begin
                                    n_phase = PH_STATW;
                                end
                            end
                            PH_CMDD: begin
                                w_ev.kind = KindCmdData;
                                n_left    = r_left - 8'd2;
                                if (r_left == 8'd2) begin
                                    n_phase = PH_STATW;
                                end
                            end
                            PH_STATW: begin
                                w_ev.kind = KindStatus;
                                if (r_resp_len > 8'd2) begin
                                    n_phase = PH_RESPD;
                                    n_left  = r_resp_len - 8'd2;
                                end else begin
                                    n_phase = PH_WAIT;
                                end
                            end
                            PH_RESPD: begin
                                w_ev.kind = KindRespData;
                                n_left    = r_left - 8'd2;
                                if (r_left == 8'd2) begin
                                    n_phase = PH_WAIT;
                                end
                            end
                            default: begin
                                o_push  = 1'b0;
                                n_phase = PH_WAIT;
                            end
                        endcase
                    end
                end
            endcase
        end
        o_event = w_ev;
    end

endmodule

// ----- sv/bmrp_queue.sv -----
// ---------------------------------------------------------------------------
// bmrp_queue
// short event queue between the parser and the result formatter
// ---------------------------------------------------------------------------
module bmrp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bmrp_pkg::t_event i_event,
    input  logic             i_pop,
    output bmrp_pkg::t_event o_event,
    output logic             o_full,
    output logic             o_empty
);
    import bmrp_pkg::*;

    t_event           r_mem [QDepth];
    logic [QPtrW-1:0] r_wr, n_wr;
    logic [QPtrW-1:0] r_rd, n_rd;
    logic [QPtrW:0]   r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_event = r_mem[r_rd];

    always_comb begin
        n_wr  = w_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QPtrW+1)'(w_push) - (QPtrW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

endmodule

// ----- sv/bmrp_back.sv -----
// ---------------------------------------------------------------------------
// bmrp_back
// result formatter: timing, interval, command word decode, output register
// ---------------------------------------------------------------------------
module bmrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  bmrp_pkg::t_event  i_event,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_kind,
    output bmrp_pkg::t_result o_result
);
    import bmrp_pkg::*;

    logic             r_valid, n_valid;
    logic [2:0]       r_kind, n_kind;
    t_result          r_res, n_res;
    logic [TimeW-1:0] r_prev, n_prev;
    logic             r_have_prev, n_have_prev;
    logic [15:0]      r_cmd, n_cmd;
    logic [TimeW-1:0] w_time;
    logic [15:0]      w_cw;
    logic             w_is_hdr;
    logic             w_use_cmd;

    assign o_pop    = i_avail && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_result = r_res;
    assign w_time   = {i_event.tick, 3'b000};
    assign w_is_hdr = (i_event.kind == KindHeader);
    assign w_cw     = w_is_hdr ? i_event.word : r_cmd;
    assign w_use_cmd = (i_event.kind == KindHeader) || (i_event.kind == KindCmdData) ||
                       (i_event.kind == KindStatus) || (i_event.kind == KindRespData);

    always_comb begin
        n_valid     = r_valid;
        n_kind      = r_kind;
        n_res       = r_res;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_cmd       = r_cmd;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_valid             = 1'b1;
            n_kind              = i_event.kind;
            n_res               = '0;
            n_res.source_marker = i_event.marker;
            n_res.time_us       = w_time;
            n_res.bus_channel   = i_event.chan;
            n_res.error_code    = i_event.err;
            if (w_is_hdr) begin
                n_prev      = w_time;
                n_have_prev = 1'b1;
                n_cmd       = i_event.word;
                if (r_have_prev && w_time > r_prev) begin
                    n_res.interval_us = w_time - r_prev;
                end
            end
            if (w_use_cmd) begin
                n_res.rt_address = w_cw[15:11];
                n_res.transmit   = w_cw[10];
                n_res.subaddress = w_cw[9:5];
                n_res.word_count = (w_cw[4:0] == 5'd0) ? 6'd32 : {1'b0, w_cw[4:0]};
                n_res.word_value = i_event.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_cmd       <= '0;
        end else begin
            r_valid     <= n_valid;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_cmd       <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_res  <= n_res;
    end

endmodule

// ----- sv/bus_monitor_record_parser.sv -----
// ---------------------------------------------------------------------------
// bus_monitor_record_parser
// decodes a captured 1553 bus monitor log, two bytes per word, into records
//
//   channel  dir  tdata                                     tuser
//   s        in   log_byte[7:0]                             -
//   m        out  source_marker .. word_value (see port)    kind[2:0]
//
// one byte accepted per cycle while the queue is not full; the event that a byte
// completes is written into the four-entry event queue as the byte is accepted,
// and is loaded from there into the output register. the parser stalls only while the queue
// is full. reset (synchronous, active low) clears parser state, queue and last
// time.
// ---------------------------------------------------------------------------
module bus_monitor_record_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // log_byte[7:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // source_marker[1:0], time_us[36:2], interval_us[71:37], bus_channel[72],
    // error_code[80:73], rt_address[85:81], transmit[86], subaddress[91:87],
    // word_count[97:92], word_value[113:98], zero[119:114]
    output logic [119:0] o_m_tdata,
    output logic [2:0]   o_m_tuser    // kind[2:0]
);
    import bmrp_pkg::*;

    logic    w_accept;
    logic    w_push;
    t_event  w_front_ev;
    t_event  w_queue_ev;
    logic    w_full;
    logic    w_empty;
    logic    w_pop;
    t_result w_res;

    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && !w_full;

    bmrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_byte  (i_s_tdata),
        .o_push  (w_push),
        .o_event (w_front_ev)
    );

    bmrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_event (w_front_ev),
        .i_pop   (w_pop),
        .o_event (w_queue_ev),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    bmrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!w_empty),
        .i_event  (w_queue_ev),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_kind   (o_m_tuser),
        .o_result (w_res)
    );

    assign o_m_tdata = {6'd0, w_res};

endmodule
